### rtl/core/hmc_pkg.sv
package hmc_pkg;

  localparam int SampleWidth = 32;
  localparam int FracBits    = 16;
  localparam int CfgWidth    = 48;
  localparam int CfgIdxWidth = 3;
  localparam int CoefWidth   = 48;
  localparam int CoefHalf    = CoefWidth / 2;
  localparam int LogWidth    = 21;
  localparam int MantWidth   = 31;
  localparam int PosWidth    = 5;
  localparam int LogRounds   = 16;
  localparam int TWidth      = 17;
  localparam int ProdWidth   = SampleWidth + CoefWidth;

  localparam logic [TWidth-1:0]   TOne      = 17'h10000;
  localparam logic [PosWidth-1:0] FracShift = PosWidth'(FracBits);

  localparam int FlagGradient = 0;
  localparam int FlagLog      = 1;
  localparam int FlagGray     = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegMinValue,
    RegMaxValue,
    RegLinCoef,
    RegLogCoef,
    RegLogMin,
    RegModeFlags,
    RegAlphaLevel,
    RegSolidColor
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleWidth-1:0] min_value;
    logic [SampleWidth-1:0] max_value;
    logic [CoefWidth-1:0]   lin_coef;
    logic [CoefWidth-1:0]   log_coef;
    logic [LogWidth-1:0]    log_min;
    logic [2:0]             mode_flags;
    logic [7:0]             alpha_level;
    logic [31:0]            solid_color;
  } cfg_t;

  typedef struct packed {
    logic                   above;
    logic                   in_range;
    logic                   use_log;
    logic [SampleWidth-1:0] diff;
  } side_t;

  function automatic logic [7:0] level(input logic [TWidth-1:0] x);
    logic [24:0] sum;
    sum = {x, 8'h00} - 25'(x) + 25'd32768;
    return sum[23:16];
  endfunction

endpackage

### rtl/core/hmc_cfg.sv
module hmc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hmc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [hmc_pkg::CfgWidth-1:0]        cfg_wdata_i,
  output hmc_pkg::cfg_t                       cfg_o
);
  import hmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegMinValue:   cfg_d.min_value   = cfg_wdata_i[SampleWidth-1:0];
        RegMaxValue:   cfg_d.max_value   = cfg_wdata_i[SampleWidth-1:0];
        RegLinCoef:    cfg_d.lin_coef    = cfg_wdata_i[CoefWidth-1:0];
        RegLogCoef:    cfg_d.log_coef    = cfg_wdata_i[CoefWidth-1:0];
        RegLogMin:     cfg_d.log_min     = cfg_wdata_i[LogWidth-1:0];
        RegModeFlags:  cfg_d.mode_flags  = cfg_wdata_i[2:0];
        RegAlphaLevel: cfg_d.alpha_level = cfg_wdata_i[7:0];
        RegSolidColor: cfg_d.solid_color = cfg_wdata_i[31:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_value:   '0,
                 max_value:   '0,
                 lin_coef:    '0,
                 log_coef:    '0,
                 log_min:     '0,
                 mode_flags:  '0,
                 alpha_level: 8'hFF,
                 solid_color: 32'hFF0000FF};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/hmc_log2.sv
module hmc_log2 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [hmc_pkg::MantWidth-1:0]      x_i,
  input  hmc_pkg::side_t                     side_i,
  output logic                               valid_o,
  output logic [hmc_pkg::LogWidth-1:0]       log_o,
  output hmc_pkg::side_t                     side_o
);
  import hmc_pkg::*;

  logic [PosWidth-1:0]  lead;
  logic                 enc_vld_q;
  logic [PosWidth-1:0]  enc_pos_q;
  logic [MantWidth-1:0] enc_x_q;
  side_t                enc_side_q;

  logic [LogRounds:0]   vld_q;
  logic [MantWidth-1:0] mant_q [LogRounds+1];
  logic [15:0]          frac_q [LogRounds+1];
  logic [PosWidth-1:0]  pos_q  [LogRounds+1];
  side_t                side_q [LogRounds+1];

  always_comb begin
    lead = '0;
    for (int i = 0; i < MantWidth; i++) begin
      if (x_i[i]) lead = PosWidth'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_vld_q <= 1'b0;
    end else begin
      enc_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    enc_pos_q  <= lead;
    enc_x_q    <= x_i;
    enc_side_q <= side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= enc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q[0] <= enc_x_q << (PosWidth'(MantWidth - 1) - enc_pos_q);
    frac_q[0] <= '0;
    pos_q[0]  <= enc_pos_q;
    side_q[0] <= enc_side_q;
  end

  for (genvar k = 0; k < LogRounds; k++) begin : g_round
    logic [2*MantWidth-1:0] sq;
    logic [MantWidth:0]     sh;

    assign sq = mant_q[k] * mant_q[k];
    assign sh = sq[2*MantWidth-1:MantWidth-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      mant_q[k+1] <= sh[MantWidth] ? sh[MantWidth:1] : sh[MantWidth-1:0];
      frac_q[k+1] <= {frac_q[k][14:0], sh[MantWidth]};
      pos_q[k+1]  <= pos_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[LogRounds];
  assign log_o   = {pos_q[LogRounds] - FracShift, frac_q[LogRounds]};
  assign side_o  = side_q[LogRounds];

endmodule

### rtl/core/hmc_scale.sv
module hmc_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hmc_pkg::cfg_t                      cfg_i,
  input  logic                               valid_i,
  input  logic [hmc_pkg::LogWidth-1:0]       log_i,
  input  hmc_pkg::side_t                     side_i,
  output logic                               valid_o,
  output logic [hmc_pkg::TWidth-1:0]         t_o
);
  import hmc_pkg::*;

  logic signed [LogWidth:0]   d;
  logic                       d_pos;
  logic [SampleWidth-1:0]     a_d;

  logic                       a_vld_q;
  logic [SampleWidth-1:0]     a_q;
  logic                       a_above_q, a_in_range_q, a_log_q;

  logic [CoefWidth-1:0]       coef;
  logic                       p_vld_q;
  logic [SampleWidth+CoefHalf-1:0] plo_q, phi_q;
  logic                       p_above_q, p_in_range_q;

  logic [ProdWidth-1:0]       prod;
  logic [ProdWidth-33:0]      quo;
  logic [TWidth-1:0]          t_d;
  logic                       t_vld_q;
  logic [TWidth-1:0]          t_q;

  assign d     = $signed({log_i[LogWidth-1], log_i}) -
                 $signed({cfg_i.log_min[LogWidth-1], cfg_i.log_min});
  assign d_pos = !d[LogWidth] && (d != '0);

  always_comb begin
    if (side_i.use_log) begin
      a_d = d_pos ? SampleWidth'(d[LogWidth-1:0]) : '0;
    end else begin
      a_d = side_i.diff;
    end
  end

  assign coef = a_log_q ? cfg_i.log_coef : cfg_i.lin_coef;

  assign prod = ProdWidth'(plo_q) + {phi_q, {CoefHalf{1'b0}}};
  assign quo  = prod[ProdWidth-1:32];

  always_comb begin
    if (p_above_q) begin
      t_d = TOne;
    end else if (!p_in_range_q) begin
      t_d = '0;
    end else if (quo > (ProdWidth-32)'(TOne)) begin
      t_d = TOne;
    end else begin
      t_d = quo[TWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      t_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      p_vld_q <= a_vld_q;
      t_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    a_above_q    <= side_i.above;
    a_in_range_q <= side_i.in_range;
    a_log_q      <= side_i.use_log;
    plo_q        <= a_q * coef[CoefHalf-1:0];
    phi_q        <= a_q * coef[CoefWidth-1:CoefHalf];
    p_above_q    <= a_above_q;
    p_in_range_q <= a_in_range_q;
    t_q          <= t_d;
  end

  assign valid_o = t_vld_q;
  assign t_o     = t_q;

endmodule

### rtl/core/hmc_color.sv
module hmc_color (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hmc_pkg::cfg_t                  cfg_i,
  input  logic                           valid_i,
  input  logic [hmc_pkg::TWidth-1:0]     t_i,
  output logic                           valid_o,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     alpha_out_o
);
  import hmc_pkg::*;

  logic [TWidth+1:0] h6;
  logic [15:0]       f;
  logic [TWidth-1:0] fx, r, g, b;
  logic [7:0]        red_d, green_d, blue_d, alpha_d;
  logic              valid_q;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;

  assign h6 = {TOne - t_i, 2'b00};
  assign f  = h6[15:0];
  assign fx = TWidth'(f);

  always_comb begin
    if (cfg_i.mode_flags[FlagGray]) begin
      r = t_i;
      g = t_i;
      b = t_i;
    end else begin
      case (h6[TWidth+1:16])
        3'd0: begin
          r = TOne;       g = fx;         b = '0;
        end
        3'd1: begin
          r = TOne - fx;  g = TOne;       b = '0;
        end
        3'd2: begin
          r = '0;         g = TOne;       b = fx;
        end
        3'd3: begin
          r = '0;         g = TOne - fx;  b = TOne;
        end
        default: begin
          r = '0;         g = '0;         b = TOne;
        end
      endcase
    end
  end

  always_comb begin
    if (cfg_i.mode_flags[FlagGradient]) begin
      red_d   = level(r);
      green_d = level(g);
      blue_d  = level(b);
      alpha_d = cfg_i.alpha_level;
    end else begin
      red_d   = cfg_i.solid_color[31:24];
      green_d = cfg_i.solid_color[23:16];
      blue_d  = cfg_i.solid_color[15:8];
      alpha_d = cfg_i.solid_color[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    alpha_q <= alpha_d;
  end

  assign valid_o     = valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_q;

endmodule

### rtl/core/value_to_heatmap_color_core.sv
// A request accepted at a clock edge shows its color on the result ports, marked
// by valid_o, after the input register, the log2, scale and color units.
// Throughput: one request per cycle; busy is always low and the receiver
// cannot stall. Most of the pipeline lies in the log2 unit: sixteen squaring stages.
// Reset clears all valid bits and loads the register defaults.
module value_to_heatmap_color_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [hmc_pkg::SampleWidth-1:0]   sample_i,
  input  logic                              cfg_we_i,
  input  logic [hmc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [hmc_pkg::CfgWidth-1:0]      cfg_wdata_i,
  output logic                              valid_o,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o,
  output logic [7:0]                        alpha_out_o
);
  import hmc_pkg::*;

  cfg_t                   cfg;
  logic                   in_vld_q;
  logic [SampleWidth-1:0] sample_q;
  side_t                  side;
  logic                   log_vld;
  logic [LogWidth-1:0]    log_val;
  side_t                  log_side;
  logic                   t_vld;
  logic [TWidth-1:0]      t;
  logic                   mn_pos;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_i;
  end

  hmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign mn_pos = !cfg.min_value[SampleWidth-1] && (cfg.min_value != '0);

  always_comb begin
    side.above    = $signed(sample_q) > $signed(cfg.max_value);
    side.in_range = ($signed(sample_q) > $signed(cfg.min_value)) &&
                    ($signed(cfg.min_value) < $signed(cfg.max_value));
    side.use_log  = cfg.mode_flags[FlagLog] && mn_pos;
    side.diff     = sample_q - cfg.min_value;
  end

  hmc_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_vld_q),
    .x_i    (sample_q[MantWidth-1:0]),
    .side_i (side),
    .valid_o(log_vld),
    .log_o  (log_val),
    .side_o (log_side)
  );

  hmc_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .valid_i(log_vld),
    .log_i  (log_val),
    .side_i (log_side),
    .valid_o(t_vld),
    .t_o    (t)
  );

  hmc_color u_color (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (t_vld),
    .t_i        (t),
    .valid_o    (valid_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .alpha_out_o(alpha_out_o)
  );

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hmc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int PlanLen    = 48;
  localparam int Phases     = 8;
  localparam int PhaseItems = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    target;
    logic [47:0] value;
    logic        typed;
    rgba_t       color;
  } plan_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic [SampleWidth-1:0] sample_i    = '0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i   = RegMinValue;
  logic [CfgWidth-1:0]    cfg_wdata_i = '0;
  logic                   valid_o;
  logic [7:0]             red_o;
  logic [7:0]             green_o;
  logic [7:0]             blue_o;
  logic [7:0]             alpha_out_o;

  logic                   typed_en    = 1'b0;
  rgba_t                  typed_color = '0;

  logic signed [31:0]     cur_min     = '0;
  logic signed [31:0]     cur_max     = '0;
  logic [47:0]            cur_lin     = '0;
  logic [47:0]            cur_log     = '0;
  logic signed [20:0]     cur_logmin  = '0;
  logic [2:0]             cur_flags   = '0;
  logic [7:0]             cur_alpha   = 8'hFF;
  logic [31:0]            cur_solid   = 32'hFF00_00FF;

  logic signed [31:0]     span_lo     = '0;
  logic signed [31:0]     span_hi     = '0;

  rgba_t                  pending_colors [$];
  int                     mismatches   = 0;
  int                     quiet_cycles = 0;

  plan_row_t plan [PlanLen] = '{
    '{RowSample, RegMinValue,   48'h7FFF_FFFF,      1'b1, 32'hFF00_00FF},
    '{RowSample, RegMinValue,   48'h8000_0000,      1'b1, 32'hFF00_00FF},
    '{RowWrite,  RegSolidColor, 48'h00FF_0000,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b1, 32'h00FF_0000},
    '{RowWrite,  RegModeFlags,  48'h1,              1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h7FFF_FFFF,      1'b1, 32'hFF00_00FF},
    '{RowSample, RegMinValue,   48'h8000_0000,      1'b1, 32'h0000_FFFF},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b1, 32'h0000_FFFF},
    '{RowWrite,  RegModeFlags,  48'h5,              1'b0, 32'h0},
    '{RowWrite,  RegAlphaLevel, 48'h0,              1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0000_0001,      1'b1, 32'hFFFF_FF00},
    '{RowSample, RegMinValue,   48'hFFFF_FFFF,      1'b1, 32'h0000_0000},
    '{RowWrite,  RegMinValue,   48'h7FFF_FFFF,      1'b0, 32'h0},
    '{RowWrite,  RegMaxValue,   48'h8000_0000,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h7FFF_FFFF,      1'b1, 32'hFFFF_FF00},
    '{RowSample, RegMinValue,   48'h8000_0000,      1'b1, 32'h0000_0000},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b1, 32'hFFFF_FF00},
    '{RowWrite,  RegMinValue,   48'hFFFF_0000,      1'b0, 32'h0},
    '{RowWrite,  RegMaxValue,   48'h0001_0000,      1'b0, 32'h0},
    '{RowWrite,  RegLinCoef,    48'h0000_8000_0000, 1'b0, 32'h0},
    '{RowWrite,  RegModeFlags,  48'h1,              1'b0, 32'h0},
    '{RowWrite,  RegAlphaLevel, 48'hFF,             1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'hFFFF_0001,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0001_0000,      1'b0, 32'h0},
    '{RowWrite,  RegLinCoef,    48'h0,              1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b1, 32'h0000_FFFF},
    '{RowWrite,  RegLinCoef,    48'hFFFF_FFFF_FFFF, 1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b1, 32'hFF00_00FF},
    '{RowWrite,  RegModeFlags,  48'h3,              1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0000_0000,      1'b0, 32'h0},
    '{RowWrite,  RegMinValue,   48'h0001_0000,      1'b0, 32'h0},
    '{RowWrite,  RegMaxValue,   48'h0100_0000,      1'b0, 32'h0},
    '{RowWrite,  RegLogMin,     48'h0,              1'b0, 32'h0},
    '{RowWrite,  RegLogCoef,    48'h0000_2000_0000, 1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0002_0000,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h00FF_FFFF,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0001_0001,      1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h7FFF_FFFF,      1'b1, 32'hFF00_00FF},
    '{RowWrite,  RegLogMin,     48'h0F_FFFF,        1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0002_0000,      1'b1, 32'h0000_FFFF},
    '{RowWrite,  RegLogMin,     48'h10_0000,        1'b0, 32'h0},
    '{RowWrite,  RegLogCoef,    48'hFFFF_FFFF_FFFF, 1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0010_0000,      1'b0, 32'h0},
    '{RowWrite,  RegModeFlags,  48'h7,              1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0080_0000,      1'b0, 32'h0},
    '{RowWrite,  RegLogCoef,    48'h0,              1'b0, 32'h0},
    '{RowSample, RegMinValue,   48'h0080_0000,      1'b1, 32'h0000_00FF}
  };

  value_to_heatmap_color_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_out_o (alpha_out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int log2_fix(input logic [31:0] x);
    int          p;
    logic [63:0] m;
    logic [15:0] frac;
    p = 31;
    while (p > 0 && !x[p]) p--;
    m = (p > 30) ? (64'(x) >> (p - 30)) : (64'(x) << (30 - p));
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], m[31]};
      if (m[31]) m = m >> 1;
    end
    return (p - 16) * 65536 + int'(frac);
  endfunction

  function automatic logic [16:0] scale_product(input logic [48:0] a, input logic [47:0] b);
    logic [96:0] prod;
    prod = (97'(a) * 97'(b)) >> 32;
    return (prod > 97'(TOne)) ? TOne : prod[16:0];
  endfunction

  function automatic logic [7:0] channel_byte(input logic [16:0] x);
    logic [24:0] s;
    s = 25'(x) * 25'd255 + 25'd32768;
    return s[23:16];
  endfunction

  function automatic rgba_t heat_color(input logic [31:0] smp);
    logic signed [31:0] v;
    logic [32:0]        span;
    logic [16:0]        t, rl, gl, bl, f;
    logic [18:0]        h6;
    int                 d;
    rgba_t              c;
    v = smp;
    if (!cur_flags[FlagGradient]) return cur_solid;
    if (v > cur_max) begin
      t = TOne;
    end else if (v > cur_min && cur_min < cur_max) begin
      if (cur_flags[FlagLog] && cur_min > 0) begin
        d = log2_fix(v) - int'(cur_logmin);
        t = (d > 0) ? scale_product(49'(d), cur_log) : '0;
      end else begin
        span = {v[31], v} - {cur_min[31], cur_min};
        t = scale_product({16'd0, span}, cur_lin);
      end
    end else begin
      t = '0;
    end
    if (cur_flags[FlagGray]) begin
      rl = t;
      gl = t;
      bl = t;
    end else begin
      h6 = 19'(TOne - t) << 2;
      f = {1'b0, h6[15:0]};
      case (h6[18:16])
        3'd0: begin rl = TOne;     gl = f;        bl = '0;   end
        3'd1: begin rl = TOne - f; gl = TOne;     bl = '0;   end
        3'd2: begin rl = '0;       gl = TOne;     bl = f;    end
        3'd3: begin rl = '0;       gl = TOne - f; bl = TOne; end
        default: begin rl = '0;    gl = '0;       bl = TOne; end
      endcase
    end
    c.red   = channel_byte(rl);
    c.green = channel_byte(gl);
    c.blue  = channel_byte(bl);
    c.alpha = cur_alpha;
    return c;
  endfunction

  task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    rgba_t got, want;
    if (rst_ni) begin
      if (valid_o) begin
        got = {red_o, green_o, blue_o, alpha_out_o};
        if (pending_colors.size() == 0) begin
          mismatches++;
          $display("%0t: expected no color, got %h", $time, got);
        end else begin
          want = pending_colors.pop_front();
          flag_field("red", want.red, got.red);
          flag_field("green", want.green, got.green);
          flag_field("blue", want.blue, got.blue);
          flag_field("alpha", want.alpha, got.alpha);
        end
      end
      if (start && !busy) begin
        pending_colors.push_back(typed_en ? typed_color : heat_color(sample_i));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegMinValue:   cur_min    = cfg_wdata_i[31:0];
          RegMaxValue:   cur_max    = cfg_wdata_i[31:0];
          RegLinCoef:    cur_lin    = cfg_wdata_i;
          RegLogCoef:    cur_log    = cfg_wdata_i;
          RegLogMin:     cur_logmin = cfg_wdata_i[20:0];
          RegModeFlags:  cur_flags  = cfg_wdata_i[2:0];
          RegAlphaLevel: cur_alpha  = cfg_wdata_i[7:0];
          RegSolidColor: cur_solid  = cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      quiet_cycles = (valid_o || (start && !busy) || cfg_we_i) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic drive_sample(input logic [31:0] x, input int idle_pct,
                              input logic typed, input rgba_t color);
    while ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      sample_i <= $urandom;
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    sample_i    <= x;
    cfg_we_i    <= 1'b0;
    typed_en    <= typed;
    typed_color <= color;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  task automatic drain();
    start    <= 1'b0;
    cfg_we_i <= 1'b0;
    do @(negedge clk_i); while (pending_colors.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic reconfigure();
    logic signed [31:0] lo, hi, tmp;
    logic [32:0]        span;
    longint unsigned    q;
    int                 lo_log, hi_log;
    logic [47:0]        lin, lg;
    logic [20:0]        lmin;
    logic [2:0]         flags;
    case ($urandom_range(5))
      0, 1: begin
        lo = $urandom_range(32'h0100_0000, 1);
        hi = lo + $urandom_range(32'h1000_0000, 1);
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
      3: begin
        lo = $urandom;
        hi = lo + $urandom_range(4);
      end
      4: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = $urandom;
        hi = lo;
      end
    endcase
    lin  = {16'($urandom), $urandom};
    lg   = {16'($urandom), $urandom};
    lmin = 21'($urandom);
    if (hi > lo) begin
      span = {hi[31], hi} - {lo[31], lo};
      q = 64'h1_0000_0000_0000 / 64'(span);
      lin = (q > 64'hFFFF_FFFF_FFFF) ? '1 : q[47:0];
    end
    if (lo > 0 && hi > lo) begin
      lo_log = log2_fix(lo);
      hi_log = log2_fix(hi);
      lmin = lo_log[20:0];
      if (hi_log > lo_log) begin
        q = 64'h1_0000_0000_0000 / 64'(hi_log - lo_log);
        lg = (q > 64'hFFFF_FFFF_FFFF) ? '1 : q[47:0];
      end
    end
    if ($urandom_range(5) == 0) lin = {16'($urandom), $urandom};
    if ($urandom_range(5) == 0) lg = {16'($urandom), $urandom};
    if ($urandom_range(5) == 0) lmin = 21'($urandom);
    flags = 3'($urandom_range(7)) | {2'b00, $urandom_range(3) != 0};
    span_lo = lo;
    span_hi = hi;
    write_reg(RegMinValue, 48'(lo));
    write_reg(RegMaxValue, 48'(hi));
    write_reg(RegLinCoef, lin);
    write_reg(RegLogCoef, lg);
    write_reg(RegLogMin, 48'(lmin));
    write_reg(RegModeFlags, 48'(flags));
    write_reg(RegAlphaLevel, 48'($urandom_range(255)));
    write_reg(RegSolidColor, 48'($urandom));
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] corner [8];
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
               span_lo, span_hi, span_lo + 1, span_hi + 1};
    case ($urandom_range(11))
      0: return $urandom;
      1: return corner[$urandom_range(7)];
      2: return span_lo - $urandom_range(3);
      3: return span_hi + $urandom_range(3);
      default: begin
        if (span_hi >= span_lo) return span_lo + $urandom_range(span_hi - span_lo);
        else return span_lo + $urandom_range(65535) - 32768;
      end
    endcase
  endfunction

  initial begin : stimulus
    logic last_write;
    int   idle_pct;
    last_write = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < PlanLen; i++) begin
      if (plan[i].kind == RowWrite) begin
        if (!last_write) drain();
        write_reg(plan[i].target, plan[i].value);
      end else begin
        drive_sample(plan[i].value[31:0], 0, plan[i].typed, plan[i].color);
      end
      last_write = (plan[i].kind == RowWrite);
    end

    for (int phase = 0; phase < Phases; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 73;
        default: idle_pct = 28;
      endcase
      drain();
      reconfigure();
      for (int n = 0; n < PhaseItems; n++) begin
        // hold requests until the pipeline runs dry
        if (n == PhaseItems / 2 && phase % 2 == 1) drain();
        drive_sample(pick_sample(), idle_pct, 1'b0, '0);
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hmc_pkg.sv
rtl/core/hmc_cfg.sv
rtl/core/hmc_log2.sv
rtl/core/hmc_scale.sv
rtl/core/hmc_color.sv
rtl/core/value_to_heatmap_color_core.sv
dv/testbench.sv
